// ----- src/dbsd_pkg.sv -----
package dbsd_pkg;

   localparam int LIST_DEPTH = 1024;
   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int XW = AW + 2;
   localparam int DW = 128;

   typedef enum logic [1:0] {
      REQ_LOAD_OLD = 2'd0,
      REQ_LOAD_NEW = 2'd1,
      REQ_DIFF     = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_NEXT,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_SIFT_LOAD,
      ST_SIFT_CH,
      ST_SIFT_C1,
      ST_SIFT_C2,
      ST_SIFT_PICK,
      ST_SIFT_CMP,
      ST_SIFT_FIN,
      ST_WALK_RD,
      ST_WALK_A,
      ST_WALK_DUP,
      ST_WALK_CMP
   } state_type;

   typedef enum logic {
      PH_BUILD,
      PH_EXTRACT
   } phase_type;

endpackage

// ----- src/dbsd_ram.sv -----
module dbsd_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/digest_bucket_set_difference.sv -----
// Loads: taken while idle and no result is held untaken, with no wait between loads.
// A diff request after loading first heap-sorts both lists through one read and one write
// port per list, sifting each root down, then walks the merge one pair at a time and skips
// duplicates. One item in flight at a time; a result stays in the output register until
// taken. Reset (synchronous, active high) clears counts, positions, flags and the state;
// list contents stay undefined until loaded.
module digest_bucket_set_difference (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_digest_hi,
   input  logic [63:0] req_digest_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic        rsp_is_added,
   output logic [63:0] rsp_diff_hi,
   output logic [63:0] rsp_diff_lo,
   output logic        rsp_overflow
);

   localparam int AW = dbsd_pkg::AW;
   localparam int CW = dbsd_pkg::CW;
   localparam int XW = dbsd_pkg::XW;
   localparam int DW = dbsd_pkg::DW;

   dbsd_pkg::state_type state_ff, state_in;
   dbsd_pkg::phase_type phase_ff, phase_in;

   logic [CW-1:0] old_count_ff, old_count_in, new_count_ff, new_count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, end_ff, end_in;
   logic [AW-1:0] root_ff, root_in, cidx_ff, cidx_in;
   logic [DW-1:0] rv_ff, rv_in, cv_ff, cv_in, t0_ff, t0_in;
   logic          lsel_ff, lsel_in, sorted_ff, sorted_in, ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in, found_ff, found_in, added_ff, added_in;
   logic [DW-1:0] diff_ff, diff_in;
   logic          ovo_ff, ovo_in;

   logic          o_we, n_we;
   logic [AW-1:0] o_wa, n_wa, o_ra, n_ra, s_wa, s_ra;
   logic [DW-1:0] o_wd, n_wd, s_wd, o_rd, n_rd, s_rd;
   logic          s_we;

   logic          accept, is_load, is_diff;
   logic [CW-1:0] n_cnt, km1, i1, j1;
   logic [XW-1:0] child, child1;
   logic          dup_o, dup_n, i_lt, j_lt, i1_lt, j1_lt;

   assign accept  = req_valid && req_ready;
   assign is_load = (req_type == dbsd_pkg::REQ_LOAD_OLD) || (req_type == dbsd_pkg::REQ_LOAD_NEW);
   assign is_diff = (req_type == dbsd_pkg::REQ_DIFF);
   assign n_cnt   = lsel_ff ? new_count_ff : old_count_ff;
   assign km1     = k_ff - CW'(1);
   assign i1      = i_ff + CW'(1);
   assign j1      = j_ff + CW'(1);
   assign child   = {1'b0, root_ff, 1'b1};
   assign child1  = child + XW'(1);
   assign s_rd    = lsel_ff ? n_rd : o_rd;
   assign i_lt    = i_ff < old_count_ff;
   assign j_lt    = j_ff < new_count_ff;
   assign i1_lt   = i1 < old_count_ff;
   assign j1_lt   = j1 < new_count_ff;
   assign dup_o   = i1_lt && (o_rd == rv_ff);
   assign dup_n   = j1_lt && (n_rd == cv_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dbsd_pkg::ST_IDLE: begin
            if (accept && is_diff) begin
               state_in = sorted_ff ? dbsd_pkg::ST_WALK_RD : dbsd_pkg::ST_SORT_NEXT;
            end
         end
         dbsd_pkg::ST_SORT_NEXT: begin
            if (phase_ff == dbsd_pkg::PH_BUILD) begin
               if (k_ff != '0) begin
                  state_in = dbsd_pkg::ST_SIFT_LOAD;
               end
            end else if (k_ff > CW'(1)) begin
               state_in = dbsd_pkg::ST_SWAP_A;
            end else if (lsel_ff) begin
               state_in = dbsd_pkg::ST_WALK_RD;
            end
         end
         dbsd_pkg::ST_SWAP_A:    state_in = dbsd_pkg::ST_SWAP_B;
         dbsd_pkg::ST_SWAP_B:    state_in = dbsd_pkg::ST_SIFT_CH;
         dbsd_pkg::ST_SIFT_LOAD: state_in = dbsd_pkg::ST_SIFT_CH;
         dbsd_pkg::ST_SIFT_CH: begin
            if (child >= XW'(end_ff)) begin
               state_in = dbsd_pkg::ST_SIFT_FIN;
            end else if (child1 < XW'(end_ff)) begin
               state_in = dbsd_pkg::ST_SIFT_C2;
            end else begin
               state_in = dbsd_pkg::ST_SIFT_C1;
            end
         end
         dbsd_pkg::ST_SIFT_C1:   state_in = dbsd_pkg::ST_SIFT_CMP;
         dbsd_pkg::ST_SIFT_C2:   state_in = dbsd_pkg::ST_SIFT_PICK;
         dbsd_pkg::ST_SIFT_PICK: state_in = dbsd_pkg::ST_SIFT_CMP;
         dbsd_pkg::ST_SIFT_CMP: begin
            state_in = (rv_ff < cv_ff) ? dbsd_pkg::ST_SIFT_CH : dbsd_pkg::ST_SIFT_FIN;
         end
         dbsd_pkg::ST_SIFT_FIN:  state_in = dbsd_pkg::ST_SORT_NEXT;
         dbsd_pkg::ST_WALK_RD: begin
            state_in = (i_lt || j_lt) ? dbsd_pkg::ST_WALK_A : dbsd_pkg::ST_IDLE;
         end
         dbsd_pkg::ST_WALK_A:    state_in = dbsd_pkg::ST_WALK_DUP;
         dbsd_pkg::ST_WALK_DUP: begin
            if (!dup_o && !dup_n) begin
               state_in = dbsd_pkg::ST_WALK_CMP;
            end
         end
         dbsd_pkg::ST_WALK_CMP: begin
            if (!i_lt || (j_lt && cv_ff < rv_ff) || !j_lt || rv_ff < cv_ff) begin
               state_in = dbsd_pkg::ST_IDLE;
            end else begin
               state_in = dbsd_pkg::ST_WALK_RD;
            end
         end
         default: state_in = dbsd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == dbsd_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      s_we = 1'b0;
      s_wa = root_ff;
      s_wd = rv_ff;
      s_ra = root_ff;
      o_ra = i_ff[AW-1:0];
      n_ra = j_ff[AW-1:0];
      case (state_ff)
         dbsd_pkg::ST_SORT_NEXT: begin
            s_ra = (phase_ff == dbsd_pkg::PH_BUILD) ? km1[AW-1:0] : '0;
         end
         dbsd_pkg::ST_SWAP_A: s_ra = km1[AW-1:0];
         dbsd_pkg::ST_SWAP_B: begin
            s_we = 1'b1;
            s_wa = km1[AW-1:0];
            s_wd = t0_ff;
         end
         dbsd_pkg::ST_SIFT_CH: s_ra = child[AW-1:0];
         dbsd_pkg::ST_SIFT_C2: s_ra = child1[AW-1:0];
         dbsd_pkg::ST_SIFT_CMP: begin
            s_we = rv_ff < cv_ff;
            s_wd = cv_ff;
         end
         dbsd_pkg::ST_SIFT_FIN: s_we = 1'b1;
         dbsd_pkg::ST_WALK_A: begin
            o_ra = i1[AW-1:0];
            n_ra = j1[AW-1:0];
         end
         dbsd_pkg::ST_WALK_DUP: begin
            o_ra = dup_o ? (i1[AW-1:0] + AW'(1)) : i1[AW-1:0];
            n_ra = dup_n ? (j1[AW-1:0] + AW'(1)) : j1[AW-1:0];
         end
         default: ;
      endcase
      o_we = 1'b0;
      n_we = 1'b0;
      o_wa = s_wa;
      n_wa = s_wa;
      o_wd = s_wd;
      n_wd = s_wd;
      if (state_ff == dbsd_pkg::ST_IDLE) begin
         o_wa = old_count_ff[AW-1:0];
         n_wa = new_count_ff[AW-1:0];
         o_wd = {req_digest_hi, req_digest_lo};
         n_wd = {req_digest_hi, req_digest_lo};
         o_we = accept && (req_type == dbsd_pkg::REQ_LOAD_OLD)
                && (old_count_ff < CW'(dbsd_pkg::LIST_DEPTH));
         n_we = accept && (req_type == dbsd_pkg::REQ_LOAD_NEW)
                && (new_count_ff < CW'(dbsd_pkg::LIST_DEPTH));
      end else if (state_ff != dbsd_pkg::ST_WALK_RD && state_ff != dbsd_pkg::ST_WALK_A
                   && state_ff != dbsd_pkg::ST_WALK_DUP
                   && state_ff != dbsd_pkg::ST_WALK_CMP) begin
         o_we = s_we && !lsel_ff;
         n_we = s_we && lsel_ff;
         o_ra = s_ra;
         n_ra = s_ra;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      old_count_in = old_count_ff;
      new_count_in = new_count_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      end_in = end_ff;
      root_in = root_ff;
      cidx_in = cidx_ff;
      rv_in = rv_ff;
      cv_in = cv_ff;
      t0_in = t0_ff;
      lsel_in = lsel_ff;
      sorted_in = sorted_ff;
      ovf_in = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in = found_ff;
      added_in = added_ff;
      diff_in = diff_ff;
      ovo_in = ovo_ff;
      case (state_ff)
         dbsd_pkg::ST_IDLE: begin
            if (accept && is_load) begin
               if (req_type == dbsd_pkg::REQ_LOAD_OLD) begin
                  if (o_we) old_count_in = old_count_ff + CW'(1);
                  else      ovf_in = 1'b1;
               end else begin
                  if (n_we) new_count_in = new_count_ff + CW'(1);
                  else      ovf_in = 1'b1;
               end
               sorted_in = 1'b0;
               i_in = '0;
               j_in = '0;
            end else if (accept && is_diff && !sorted_ff) begin
               lsel_in = 1'b0;
               phase_in = dbsd_pkg::PH_BUILD;
               k_in = old_count_ff >> 1;
            end
         end
         dbsd_pkg::ST_SORT_NEXT: begin
            if (phase_ff == dbsd_pkg::PH_BUILD) begin
               if (k_ff != '0) begin
                  root_in = km1[AW-1:0];
                  end_in = n_cnt;
                  k_in = km1;
               end else begin
                  phase_in = dbsd_pkg::PH_EXTRACT;
                  k_in = n_cnt;
               end
            end else if (k_ff <= CW'(1)) begin
               if (!lsel_ff) begin
                  lsel_in = 1'b1;
                  phase_in = dbsd_pkg::PH_BUILD;
                  k_in = new_count_ff >> 1;
               end else begin
                  sorted_in = 1'b1;
                  i_in = '0;
                  j_in = '0;
               end
            end
         end
         dbsd_pkg::ST_SWAP_A: t0_in = s_rd;
         dbsd_pkg::ST_SWAP_B: begin
            rv_in = s_rd;
            root_in = '0;
            end_in = km1;
            k_in = km1;
         end
         dbsd_pkg::ST_SIFT_LOAD: rv_in = s_rd;
         dbsd_pkg::ST_SIFT_C1: begin
            cv_in = s_rd;
            cidx_in = child[AW-1:0];
         end
         dbsd_pkg::ST_SIFT_C2: begin
            cv_in = s_rd;
            cidx_in = child[AW-1:0];
         end
         dbsd_pkg::ST_SIFT_PICK: begin
            if (cv_ff < s_rd) begin
               cv_in = s_rd;
               cidx_in = child1[AW-1:0];
            end
         end
         dbsd_pkg::ST_SIFT_CMP: begin
            if (rv_ff < cv_ff) root_in = cidx_ff;
         end
         dbsd_pkg::ST_WALK_RD: begin
            if (!i_lt && !j_lt) begin
               rsp_valid_in = 1'b1;
               found_in = 1'b0;
               added_in = 1'b0;
               diff_in = '0;
               ovo_in = ovf_ff;
               old_count_in = '0;
               new_count_in = '0;
               i_in = '0;
               j_in = '0;
               sorted_in = 1'b0;
               ovf_in = 1'b0;
            end
         end
         dbsd_pkg::ST_WALK_A: begin
            rv_in = o_rd;
            cv_in = n_rd;
         end
         dbsd_pkg::ST_WALK_DUP: begin
            if (dup_o) i_in = i1;
            if (dup_n) j_in = j1;
         end
         dbsd_pkg::ST_WALK_CMP: begin
            ovo_in = ovf_ff;
            found_in = 1'b1;
            if (!i_lt || (j_lt && cv_ff < rv_ff)) begin
               rsp_valid_in = 1'b1;
               added_in = 1'b1;
               diff_in = cv_ff;
               j_in = j1;
            end else if (!j_lt || rv_ff < cv_ff) begin
               rsp_valid_in = 1'b1;
               added_in = 1'b0;
               diff_in = rv_ff;
               i_in = i1;
            end else begin
               i_in = i1;
               j_in = j1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbsd_pkg::ST_IDLE;
         phase_ff <= dbsd_pkg::PH_BUILD;
         old_count_ff <= '0;
         new_count_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
         lsel_ff <= 1'b0;
         sorted_ff <= 1'b0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         old_count_ff <= old_count_in;
         new_count_ff <= new_count_in;
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
         lsel_ff <= lsel_in;
         sorted_ff <= sorted_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff <= end_in;
      root_ff <= root_in;
      cidx_ff <= cidx_in;
      rv_ff <= rv_in;
      cv_ff <= cv_in;
      t0_ff <= t0_in;
      found_ff <= found_in;
      added_ff <= added_in;
      diff_ff <= diff_in;
      ovo_ff <= ovo_in;
   end

   dbsd_ram #(.WIDTH(DW), .DEPTH(dbsd_pkg::LIST_DEPTH)) u_old_ram (
      .clock(clock), .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd),
      .rd_addr(o_ra), .rd_data(o_rd)
   );

   dbsd_ram #(.WIDTH(DW), .DEPTH(dbsd_pkg::LIST_DEPTH)) u_new_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_addr(n_ra), .rd_data(n_rd)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_is_added = added_ff;
   assign rsp_diff_hi  = diff_ff[DW-1:64];
   assign rsp_diff_lo  = diff_ff[63:0];
   assign rsp_overflow = ovo_ff;

endmodule

// ----- src/dbsd_check.sv -----
module dbsd_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_type,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic        rsp_is_added,
   input logic [63:0] rsp_diff_hi,
   input logic [63:0] rsp_diff_lo
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_diff_hi) && $stable(rsp_diff_lo))
      else $error("result beat changed while stalled");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> !rsp_is_added && rsp_diff_hi == 64'd0 && rsp_diff_lo == 64'd0)
      else $error("finished beat carries a digest");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type != dbsd_pkg::REQ_DIFF && !rsp_valid |=> !rsp_valid)
      else $error("load produced a result beat");

   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat after reset");

endmodule

bind digest_bucket_set_difference dbsd_check u_dbsd_check (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_type(req_type), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_found(rsp_found), .rsp_is_added(rsp_is_added),
   .rsp_diff_hi(rsp_diff_hi), .rsp_diff_lo(rsp_diff_lo)
);

// ----- sim/tb_top.sv -----
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 400000;

   typedef struct packed {
      bit         found;
      bit         added;
      bit [127:0] digest;
      bit         ovf;
   } diff_result_type;

   class diff_scoreboard;
      bit [127:0]      old_list[$];
      bit [127:0]      new_list[$];
      int              old_pos;
      int              new_pos;
      bit              sorted;
      bit              ovf;
      diff_result_type expected[$];
      int              mismatches;
      bit              last_found;

      function void push_result(bit found, bit added, bit [127:0] digest);
         diff_result_type r;
         r.found = found;
         r.added = added;
         r.digest = digest;
         r.ovf = ovf;
         expected.insert(expected.size(), r);
         last_found = found;
      endfunction

      function void note_beat(dbsd_pkg::req_code_type kind, bit [63:0] hi, bit [63:0] lo);
         int i, j, mi, mj;
         if (kind == dbsd_pkg::REQ_LOAD_OLD || kind == dbsd_pkg::REQ_LOAD_NEW) begin
            if (kind == dbsd_pkg::REQ_LOAD_OLD) begin
               if (old_list.size() >= dbsd_pkg::LIST_DEPTH) ovf = 1;
               else old_list.insert(old_list.size(), {hi, lo});
            end else begin
               if (new_list.size() >= dbsd_pkg::LIST_DEPTH) ovf = 1;
               else new_list.insert(new_list.size(), {hi, lo});
            end
            sorted = 0;
            old_pos = 0;
            new_pos = 0;
            return;
         end
         if (kind != dbsd_pkg::REQ_DIFF) return;
         if (!sorted) begin
            old_list.sort();
            new_list.sort();
            sorted = 1;
            old_pos = 0;
            new_pos = 0;
         end
         i = old_pos;
         j = new_pos;
         mi = old_list.size();
         mj = new_list.size();
         while (i < mi || j < mj) begin
            while (i + 1 < mi && old_list[i] == old_list[i+1]) i++;
            while (j + 1 < mj && new_list[j] == new_list[j+1]) j++;
            if (i >= mi || (j < mj && new_list[j] < old_list[i])) begin
               push_result(1, 1, new_list[j]);
               old_pos = i;
               new_pos = j + 1;
               return;
            end
            if (j >= mj || old_list[i] < new_list[j]) begin
               push_result(1, 0, old_list[i]);
               old_pos = i + 1;
               new_pos = j;
               return;
            end
            i++;
            j++;
         end
         push_result(0, 0, '0);
         old_list.delete();
         new_list.delete();
         old_pos = 0;
         new_pos = 0;
         sorted = 0;
         ovf = 0;
      endfunction

      function void check_beat(bit found, bit added, bit [63:0] hi, bit [63:0] lo, bit ov);
         diff_result_type e;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: found=%0d added=%0d %h_%h ovf=%0d",
                        found, added, hi, lo, ov);
            return;
         end
         e = expected.pop_front();
         if (e.found !== found || e.added !== added || e.digest !== {hi, lo} ||
             e.ovf !== ov) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp found=%0d added=%0d %h ovf=%0d, got %0d %0d %h_%h %0d",
                        e.found, e.added, e.digest, e.ovf, found, added, hi, lo, ov);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_type = dbsd_pkg::REQ_UNUSED;
   logic [63:0] req_digest_hi = '0;
   logic [63:0] req_digest_lo = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_found;
   logic        rsp_is_added;
   logic [63:0] rsp_diff_hi;
   logic [63:0] rsp_diff_lo;
   logic        rsp_overflow;

   diff_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   int stall_cycles = 0;
   int sent = 0;
   bit [127:0] pool[16];

   digest_bucket_set_difference dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
      if (rsp_valid && rsp_ready)
         sb.check_beat(rsp_found, rsp_is_added, rsp_diff_hi, rsp_diff_lo, rsp_overflow);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic send_beat(dbsd_pkg::req_code_type kind, bit [63:0] hi, bit [63:0] lo);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1;
      req_type <= kind;
      req_digest_hi <= hi;
      req_digest_lo <= lo;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_beat(kind, hi, lo);
      sent++;
   endtask

   task automatic drain_bucket();
      do send_beat(dbsd_pkg::REQ_DIFF, {$urandom, $urandom}, {$urandom, $urandom});
      while (sb.last_found);
   endtask

   function automatic bit [127:0] pick_digest();
      if ($urandom_range(3) == 0) return {$urandom, $urandom, $urandom, $urandom};
      return pool[$urandom_range(15)];
   endfunction

   task automatic random_bucket();
      int n_old, n_new, k;
      bit [127:0] d;
      n_old = $urandom_range(8);
      n_new = $urandom_range(8);
      for (k = 0; k < n_old + n_new; k++) begin
         d = pick_digest();
         send_beat((k < n_old) ? dbsd_pkg::REQ_LOAD_OLD : dbsd_pkg::REQ_LOAD_NEW,
                   d[127:64], d[63:0]);
      end
      if ($urandom_range(9) == 0) send_beat(dbsd_pkg::REQ_UNUSED, {$urandom, $urandom}, '0);
      if ($urandom_range(4) == 0) begin
         send_beat(dbsd_pkg::REQ_DIFF, '0, '0);
         d = pick_digest();
         send_beat($urandom_range(1) ? dbsd_pkg::REQ_LOAD_NEW : dbsd_pkg::REQ_LOAD_OLD,
                   d[127:64], d[63:0]);
      end
      drain_bucket();
   endtask

   initial begin
      int k;
      for (k = 0; k < 16; k++) begin
         pool[k] = {$urandom, $urandom, $urandom, $urandom};
         if (k % 4 == 1) pool[k][127:64] = pool[k-1][127:64];
      end
      repeat (12) @(posedge clock);
      reset <= 0;

      send_beat(dbsd_pkg::REQ_DIFF, '0, '0);
      send_beat(dbsd_pkg::REQ_UNUSED, '1, '1);
      send_beat(dbsd_pkg::REQ_LOAD_OLD, '0, '0);
      send_beat(dbsd_pkg::REQ_LOAD_OLD, '1, '1);
      send_beat(dbsd_pkg::REQ_LOAD_OLD, 64'h5, 64'h1);
      send_beat(dbsd_pkg::REQ_LOAD_OLD, 64'h5, 64'h1);
      send_beat(dbsd_pkg::REQ_LOAD_NEW, '1, '1);
      send_beat(dbsd_pkg::REQ_LOAD_NEW, 64'h5, 64'h2);
      send_beat(dbsd_pkg::REQ_LOAD_NEW, 64'h5, 64'h2);
      send_beat(dbsd_pkg::REQ_LOAD_NEW, 64'h4, '1);
      send_beat(dbsd_pkg::REQ_DIFF, '0, '0);
      send_beat(dbsd_pkg::REQ_LOAD_NEW, 64'h8000_0000_0000_0000, '0);
      drain_bucket();
      send_beat(dbsd_pkg::REQ_LOAD_NEW, '0, 64'h1);
      drain_bucket();

      send_idle = 26;
      recv_idle = 52;
      while (sent < 300) random_bucket();
      send_idle = 52;
      recv_idle = 26;
      while (sent < 560) random_bucket();
      send_idle = 0;
      recv_idle = 0;
      while (sent < 800) random_bucket();

      @(posedge clock);
      req_valid <= 0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule
